/* rtl/gam_pkg.sv */
package gam_pkg;

    localparam int BYTE_W     = 8;
    localparam int IN_TDATA_W = 3 * BYTE_W;
    localparam int IN_TUSER_W = 1;
    localparam int OUT_TDATA_W = BYTE_W;
    localparam int OUT_TUSER_W = 1;

    // Low byte of the AES reduction polynomial x^8+x^4+x^3+x+1.
    localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1B;
    localparam int GF_SIZE = 1 << BYTE_W;

    typedef enum logic {
        CMD_MASK   = 1'b0,
        CMD_UNMASK = 1'b1
    } command_t;

    typedef logic [GF_SIZE-1:0][BYTE_W-1:0] inv_table_t;

    // Operands for the single multiplication, together with the byte to be
    // XORed afterwards and the illegal-mask flag.
    typedef struct packed {
        logic [BYTE_W-1:0] op_a;
        logic [BYTE_W-1:0] op_b;
        logic [BYTE_W-1:0] post_xor;
        logic              mask_error;
    } prep_t;

    // Shift-and-add multiplication in GF(2^8), one bit of b per step.
    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        acc = '0;
        x   = a;
        for (int i = 0; i < BYTE_W; i++) begin
            if (b[i])
            begin
                acc = acc ^ x;
            end
            if (x[BYTE_W-1])
            begin
                x = {x[BYTE_W-2:0], 1'b0} ^ GF_POLY_LOW;
            end
            else
            begin
                x = {x[BYTE_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // Inverse table, built at elaboration by search. Entry zero stays zero.
    function automatic inv_table_t build_inv_table();
        inv_table_t tbl;
        tbl = '0;
        for (int a = 1; a < GF_SIZE; a++) begin
            for (int b = 1; b < GF_SIZE; b++) begin
                if (gf_mul(BYTE_W'(a), BYTE_W'(b)) == BYTE_W'(1))
                begin
                    tbl[BYTE_W'(a)] = BYTE_W'(b);
                end
            end
        end
        return tbl;
    endfunction

    localparam inv_table_t GF_INV_TABLE = build_inv_table();

endpackage

/* rtl/gam_prep.sv */
module gam_prep (
    input  logic                        command,
    input  logic [gam_pkg::BYTE_W-1:0]  data_byte,
    input  logic [gam_pkg::BYTE_W-1:0]  add_mask,
    input  logic [gam_pkg::BYTE_W-1:0]  mul_mask,
    output gam_pkg::prep_t              prep
);
    import gam_pkg::*;

    // Masking multiplies first and XORs after; unmasking XORs first and
    // multiplies by the inverse of the mask.
    always_comb
    begin
        prep.mask_error = (mul_mask == '0);
        case (command_t'(command))
            CMD_MASK:
            begin
                prep.op_a     = data_byte;
                prep.op_b     = mul_mask;
                prep.post_xor = add_mask;
            end
            CMD_UNMASK:
            begin
                prep.op_a     = data_byte ^ add_mask;
                prep.op_b     = GF_INV_TABLE[mul_mask];
                prep.post_xor = '0;
            end
            default:
            begin
                prep.op_a     = data_byte;
                prep.op_b     = mul_mask;
                prep.post_xor = add_mask;
            end
        endcase
    end

endmodule

/* rtl/gam_mul.sv */
module gam_mul (
    input  gam_pkg::prep_t              prep,
    output logic [gam_pkg::BYTE_W-1:0]  result_byte,
    output logic                        mask_error
);
    import gam_pkg::*;

    // An illegal mask forces the result to zero.
    always_comb
    begin
        mask_error = prep.mask_error;
        if (prep.mask_error)
        begin
            result_byte = '0;
        end
        else
        begin
            result_byte = gf_mul(prep.op_a, prep.op_b) ^ prep.post_xor;
        end
    end

endmodule

/* rtl/gf256_affine_mask_unmask.sv */
// Channel   Direction  tdata (lowest bit first)               tuser
// s_axis    in         data_byte, add_mask, mul_mask (24 b)   command
// m_axis    out        result_byte (8 b)                      mask_error
//
// Every request passes three registered stages, in this order: an input
// register, an operand register (after the inverse-table lookup) and a
// result register. One request is accepted per cycle while m_axis is not
// stalled; the rate is set by the single GF(2^8) multiplier, which is
// used once per request. Reset clears the stage valid flags only.
// A stall on m_axis backs up the stages one by one, and s_axis_tready
// falls only when all three are full.
module gf256_affine_mask_unmask (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // data_byte [7:0], add_mask [15:8], mul_mask [23:16]
    input  logic [gam_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // command [0]
    input  logic [gam_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // result_byte [7:0]
    output logic [gam_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // mask_error [0]
    output logic [gam_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);
    import gam_pkg::*;

    // Stage valid flags.
    logic in_valid_reg, in_valid_next;
    logic op_valid_reg, op_valid_next;
    logic res_valid_reg, res_valid_next;

    // Stage payloads.
    logic [IN_TDATA_W-1:0] in_data_reg, in_data_next;
    logic [IN_TUSER_W-1:0] in_user_reg, in_user_next;
    prep_t                 op_reg, op_next;
    logic [BYTE_W-1:0]     res_byte_reg, res_byte_next;
    logic                  res_err_reg, res_err_next;

    // Advance enables: a stage moves on when it is empty or its successor
    // moves on too.
    logic res_adv;
    logic op_adv;
    logic in_adv;

    prep_t             prep;
    logic [BYTE_W-1:0] mul_result;
    logic              mul_error;

    assign res_adv       = !res_valid_reg || m_axis_tready;
    assign op_adv        = !op_valid_reg || res_adv;
    assign in_adv        = !in_valid_reg || op_adv;
    assign s_axis_tready = in_adv;

    gam_prep u_prep (
        .command   (in_user_reg[0]),
        .data_byte (in_data_reg[BYTE_W-1:0]),
        .add_mask  (in_data_reg[2*BYTE_W-1:BYTE_W]),
        .mul_mask  (in_data_reg[3*BYTE_W-1:2*BYTE_W]),
        .prep      (prep)
    );

    gam_mul u_mul (
        .prep        (op_reg),
        .result_byte (mul_result),
        .mask_error  (mul_error)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        in_user_next   = in_user_reg;
        op_valid_next  = op_valid_reg;
        op_next        = op_reg;
        res_valid_next = res_valid_reg;
        res_byte_next  = res_byte_reg;
        res_err_next   = res_err_reg;

        if (in_adv)
        begin
            in_valid_next = s_axis_tvalid;
            in_data_next  = s_axis_tdata;
            in_user_next  = s_axis_tuser;
        end
        if (op_adv)
        begin
            op_valid_next = in_valid_reg;
            op_next       = prep;
        end
        if (res_adv)
        begin
            res_valid_next = op_valid_reg;
            res_byte_next  = mul_result;
            res_err_next   = mul_error;
        end
    end

    // Control flags take the reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            op_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            op_valid_reg  <= op_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        in_user_reg  <= in_user_next;
        op_reg       <= op_next;
        res_byte_reg <= res_byte_next;
        res_err_reg  <= res_err_next;
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = res_byte_reg;
    assign m_axis_tuser  = res_err_reg;

    // An illegal mask always delivers a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("mask error reported with a nonzero result byte");

    // Back-pressure reaches the input only when every stage is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && op_valid_reg && res_valid_reg))
    else $error("input stalled while a stage was empty");

    // An accepted request occupies the input stage in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> in_valid_reg)
    else $error("accepted request lost at the input stage");

    // A delivered result that was not refilled leaves the output empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && !op_valid_reg) |=> !m_axis_tvalid)
    else $error("result repeated after delivery");

endmodule

/* sim/tb_gf256_affine_mask_unmask.sv */
`timescale 1ns / 1ps

module tb_gf256_affine_mask_unmask;

    import gam_pkg::*;

    // Order of the multiplicative group of GF(2^8).
    localparam int GROUP_ORDER = 255;
    // Pipeline depth is three stages, so the drain below is ample.
    localparam int DRAIN_CYCLES = 12;
    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_REQUESTS = 1000;
    // The receiver holds off once, for this long, after this many requests.
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int SINK_STALL_AT = 100;
    // Window of requests during which neither side idles.
    localparam int QUIET_FROM = 500;
    localparam int QUIET_TO = 800;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        command_t          command;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] add_mask;
        logic [BYTE_W-1:0] mul_mask;
    } mask_req_t;

    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              mask_error;
    } mask_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // data_byte [7:0], add_mask [15:8], mul_mask [23:16]
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // command [0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // result_byte [7:0]
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // mask_error [0]
    logic [OUT_TUSER_W-1:0] m_axis_tuser;

    // Antilog and log tables to generator 3, filled before the first request.
    logic [BYTE_W-1:0] gf_antilog [0:GROUP_ORDER-1];
    int                gf_log [0:GF_SIZE-1];

    mask_req_t    pending_requests [$];
    mask_result_t awaited_results [$];
    mask_req_t    offered_req;

    logic in_accepted = 1'b0;
    int   requests_sent = 0;
    int   sink_hold_left = 0;
    logic sink_stall_done = 1'b0;
    int   mismatch_count = 0;
    int   cycle_count = 0;
    logic idle_allowed;

    gf256_affine_mask_unmask dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Both sides run flat out while the request count is inside the quiet window.
    assign idle_allowed = !(requests_sent >= QUIET_FROM && requests_sent < QUIET_TO);

    // Field product via the log tables; zero in either operand gives zero.
    function automatic logic [BYTE_W-1:0] field_product(input logic [BYTE_W-1:0] a,
                                                        input logic [BYTE_W-1:0] b);
        if (a == '0 || b == '0)
        begin
            return '0;
        end
        return gf_antilog[(gf_log[a] + gf_log[b]) % GROUP_ORDER];
    endfunction

    // Expected response to one request. An illegal (zero) multiplicative
    // mask gives a zero byte with the error flag, whatever the command.
    function automatic mask_result_t predict_affine(input mask_req_t r);
        mask_result_t res;
        logic [BYTE_W-1:0] mul_inverse;
        res.mask_error  = (r.mul_mask == '0);
        res.result_byte = '0;
        if (!res.mask_error)
        begin
            if (r.command == CMD_MASK)
            begin
                res.result_byte = field_product(r.data_byte, r.mul_mask) ^ r.add_mask;
            end
            else
            begin
                mul_inverse = gf_antilog[(GROUP_ORDER - gf_log[r.mul_mask]) % GROUP_ORDER];
                res.result_byte = field_product(r.data_byte ^ r.add_mask, mul_inverse);
            end
        end
        return res;
    endfunction

    task automatic queue_request(input command_t cmd, input logic [BYTE_W-1:0] data,
                                 input logic [BYTE_W-1:0] addm,
                                 input logic [BYTE_W-1:0] mulm);
        mask_req_t r;
        r.command   = cmd;
        r.data_byte = data;
        r.add_mask  = addm;
        r.mul_mask  = mulm;
        pending_requests.push_back(r);
    endtask

    // Acceptance is sampled at the rising edge and acted on by the driver at
    // the following falling edge.
    always @(posedge clk)
    begin
        in_accepted <= rst_n && s_axis_tvalid && s_axis_tready;
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Driver: the prediction for a request is queued on the falling edge after
    // its acceptance, which is always before the block can answer it. A held
    // request is never withdrawn; idle gaps are only inserted between requests.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (in_accepted)
            begin
                awaited_results.push_back(predict_affine(offered_req));
                requests_sent <= requests_sent + 1;
            end
            if (!s_axis_tvalid || in_accepted)
            begin
                if (pending_requests.size() > 0
                    && !(idle_allowed && $urandom_range(99) < 10))
                begin
                    offered_req = pending_requests.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {offered_req.mul_mask, offered_req.add_mask,
                                      offered_req.data_byte};
                    s_axis_tuser  <= offered_req.command;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness. Once, early in the random part, it holds off for a
    // long stretch so that all three stages fill and the input stalls.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (sink_hold_left > 0)
        begin
            m_axis_tready  <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end
        else if (!sink_stall_done && requests_sent >= SINK_STALL_AT)
        begin
            m_axis_tready   <= 1'b0;
            sink_hold_left  <= SINK_HOLD_CYCLES;
            sink_stall_done <= 1'b1;
        end
        else
        begin
            m_axis_tready <= !(idle_allowed && $urandom_range(99) < 10);
        end
    end

    // Monitor: each accepted response is compared with the oldest prediction.
    always @(posedge clk)
    begin : check_responses
        mask_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (awaited_results.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                begin
                    $display("unexpected response: result_byte %02h mask_error %0b",
                             m_axis_tdata, m_axis_tuser[0]);
                end
                mismatch_count <= mismatch_count + 1;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (m_axis_tdata !== want.result_byte || m_axis_tuser[0] !== want.mask_error)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("mismatch: expected result_byte %02h mask_error %0b, got %02h %0b",
                                 want.result_byte, want.mask_error,
                                 m_axis_tdata, m_axis_tuser[0]);
                    end
                    mismatch_count <= mismatch_count + 1;
                end
            end
        end
    end

    initial
    begin
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] addm;
        logic [BYTE_W-1:0] mulm;
        logic [BYTE_W-1:0] data;
        mask_req_t         r;
        mask_result_t      masked;
        int                queued;

        // Powers of 3: multiplying by 3 is the element XORed with its double.
        x = 8'h01;
        gf_log[0] = 0;
        for (int i = 0; i < GROUP_ORDER; i++)
        begin
            gf_antilog[i] = x;
            gf_log[x] = i;
            x = x ^ ({x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY_LOW : 8'h00));
        end

        // Directed requests: byte extremes, zero data on both paths, the
        // identity and top masks, an inverse pair, and the illegal zero mask.
        queue_request(CMD_MASK,   8'h00, 8'h00, 8'h01);
        queue_request(CMD_MASK,   8'hFF, 8'hFF, 8'hFF);
        queue_request(CMD_MASK,   8'h00, 8'hA5, 8'h37);
        queue_request(CMD_MASK,   8'h80, 8'h00, 8'h02);
        queue_request(CMD_MASK,   8'h01, 8'h00, 8'hFF);
        queue_request(CMD_MASK,   8'h53, 8'h00, 8'hCA);
        queue_request(CMD_MASK,   8'hFF, 8'h00, 8'h01);
        queue_request(CMD_MASK,   8'h02, 8'hFF, 8'h8D);
        queue_request(CMD_UNMASK, 8'hA5, 8'hA5, 8'h37);
        queue_request(CMD_UNMASK, 8'hFF, 8'h00, 8'hFF);
        queue_request(CMD_UNMASK, 8'h00, 8'h00, 8'h01);
        queue_request(CMD_UNMASK, 8'h00, 8'hFF, 8'h80);
        queue_request(CMD_UNMASK, 8'hC3, 8'h5A, 8'h01);
        queue_request(CMD_UNMASK, 8'hFF, 8'hFF, 8'hFF);
        queue_request(CMD_UNMASK, 8'h01, 8'h00, 8'h53);
        queue_request(CMD_MASK,   8'h7F, 8'h80, 8'h00);
        queue_request(CMD_UNMASK, 8'h7F, 8'h80, 8'h00);
        queue_request(CMD_MASK,   8'h00, 8'h00, 8'h00);
        queue_request(CMD_UNMASK, 8'hFF, 8'hFF, 8'h00);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The sender pauses here until every directed response is back.
        while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);

        // Random part: mostly a mask request followed by the matching unmask
        // of its predicted output, so round trips are exercised, mixed with
        // unrelated requests. About one mask in twenty is the illegal zero.
        queued = 0;
        while (queued < RANDOM_REQUESTS)
        begin
            data = 8'($urandom_range(255));
            addm = 8'($urandom_range(255));
            mulm = ($urandom_range(99) < 5) ? 8'h00 : 8'($urandom_range(255));
            if ($urandom_range(99) < 60)
            begin
                r.command   = CMD_MASK;
                r.data_byte = data;
                r.add_mask  = addm;
                r.mul_mask  = mulm;
                masked      = predict_affine(r);
                queue_request(CMD_MASK, data, addm, mulm);
                queue_request(CMD_UNMASK, masked.result_byte, addm, mulm);
                queued += 2;
            end
            else
            begin
                queue_request($urandom_range(1) ? CMD_UNMASK : CMD_MASK, data, addm, mulm);
                queued += 1;
            end
        end

        while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge clk);
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (mismatch_count == 0 && awaited_results.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/gam_pkg.sv
rtl/gam_prep.sv
rtl/gam_mul.sv
rtl/gf256_affine_mask_unmask.sv
sim/tb_gf256_affine_mask_unmask.sv
